/* design/lld_pkg.sv */
// ----------------------------------------------------------------------------
// lld_pkg
// Shared types and constants for the least-loaded dispatcher with affinity.
// ----------------------------------------------------------------------------
package lld_pkg;

	localparam int MAX_WORKERS   = 16;
	localparam int TABLE_ENTRIES = 16;

	localparam int WIDX_W   = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
	localparam int EIDX_W   = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int NACT_W   = $clog2(MAX_WORKERS + 1);
	localparam int SCAN_LEN = (MAX_WORKERS > TABLE_ENTRIES) ? MAX_WORKERS : TABLE_ENTRIES;
	localparam int SCAN_W   = $clog2(SCAN_LEN + 1);

	localparam int CNT_W = 16;
	localparam logic [CNT_W-1:0] CNT_MAX = 16'hFFFF;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;

	localparam logic [CFG_IDX_W-1:0] REG_KEEP_ORDER     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WORKERS_IN_USE = 1'd1;

	localparam logic KEEP_ORDER_RST = 1'b1;
	localparam logic [4:0] WORKERS_IN_USE_RST = 5'd16;

	localparam logic CMD_SUBMIT = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	localparam logic [1:0] ST_DISPATCHED = 2'd0;
	localparam logic [1:0] ST_REJECTED   = 2'd1;
	localparam logic [1:0] ST_FINISHED   = 2'd2;

	typedef struct packed {
		logic        cmd;
		logic [15:0] source_id;
		logic [3:0]  done_worker;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [3:0]  assigned_worker;
		logic        release_res;
		logic [15:0] echo_source;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic start;
		logic scan;
		logic lookup;
		logic commit;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic scan_done;
	} dp_stat_t;

endpackage

/* design/lld_ctrl.sv */
// ----------------------------------------------------------------------------
// lld_ctrl
// Sequencer: accept, scan of table and worker loads, load lookup, commit.
// ----------------------------------------------------------------------------
module lld_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output lld_pkg::dp_cmd_t dp_cmd,
	input  lld_pkg::dp_stat_t dp_stat
);
	import lld_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_LOOKUP,
		S_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	assign dp_cmd.start  = (state_q == S_IDLE) && in_valid;
	assign dp_cmd.scan   = (state_q == S_SCAN);
	assign dp_cmd.lookup = (state_q == S_LOOKUP);
	assign dp_cmd.commit = (state_q == S_COMMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((state_q == S_COMMIT) && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid)
						state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (dp_stat.scan_done)
						state_q <= S_LOOKUP;
				end
				S_LOOKUP: begin
					state_q <= S_COMMIT;
				end
				S_COMMIT: begin
					if (out_free)
						state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

/* design/lld_datapath.sv */
// ----------------------------------------------------------------------------
// lld_datapath
// Worker loads, affinity table, config registers, scan and update logic.
// ----------------------------------------------------------------------------
module lld_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  lld_pkg::req_t                   in_data,
	output lld_pkg::rsp_t                   out_data,
	input  logic                            cfg_we,
	input  logic [lld_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lld_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  lld_pkg::dp_cmd_t                dp_cmd,
	output lld_pkg::dp_stat_t               dp_stat
);
	import lld_pkg::*;

	// config
	logic       keep_q;
	logic [4:0] wiu_q;
	logic [NACT_W-1:0] n_act;

	// state
	logic [CNT_W-1:0]  worker_load_q [MAX_WORKERS];
	logic              entry_valid_q [TABLE_ENTRIES];
	logic [15:0]       entry_source_q [TABLE_ENTRIES];
	logic [CNT_W-1:0]  entry_count_q [TABLE_ENTRIES];
	logic [WIDX_W-1:0] entry_worker_q [TABLE_ENTRIES];

	// per-transaction
	req_t              req_q;
	logic [SCAN_W-1:0] scan_idx_q;
	logic              hit_q;
	logic [EIDX_W-1:0] hit_idx_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic [WIDX_W-1:0] hit_wkr_q;
	logic              free_q;
	logic [EIDX_W-1:0] free_idx_q;
	logic [WIDX_W-1:0] best_idx_q;
	logic [CNT_W-1:0]  best_load_q;
	logic [CNT_W-1:0]  load_rd_q;
	rsp_t              rsp_q;

	logic              ent_in;
	logic              wkr_in;
	logic [EIDX_W-1:0] ei;
	logic [WIDX_W-1:0] wi;

	logic              is_submit;
	logic              use_hit;
	logic              new_entry;
	logic              reject;
	logic [EIDX_W-1:0] slot;
	logic [WIDX_W-1:0] tw;
	logic              load_ok;
	logic [CNT_W-1:0]  new_load;
	logic [CNT_W-1:0]  cnt_inc;
	logic [CNT_W-1:0]  cnt_dec;
	logic              fin_release;
	rsp_t              rsp_d;

	always_comb begin
		if (wiu_q == 5'd0)
			n_act = NACT_W'(1);
		else if (32'(wiu_q) > 32'(MAX_WORKERS))
			n_act = NACT_W'(MAX_WORKERS);
		else
			n_act = NACT_W'(wiu_q);
	end

	assign ei     = scan_idx_q[EIDX_W-1:0];
	assign wi     = scan_idx_q[WIDX_W-1:0];
	assign ent_in = 32'(scan_idx_q) < 32'(TABLE_ENTRIES);
	assign wkr_in = (32'(scan_idx_q) < 32'(MAX_WORKERS)) &&
		(32'(scan_idx_q) < 32'(n_act));

	assign dp_stat.scan_done = (scan_idx_q == SCAN_W'(SCAN_LEN - 1));

	// decision from scan results
	always_comb begin
		is_submit = (req_q.cmd == CMD_SUBMIT);
		use_hit   = keep_q && hit_q;
		new_entry = !use_hit && (hit_q || free_q);
		reject    = is_submit && !use_hit && !hit_q && !free_q;
		slot      = hit_q ? hit_idx_q : free_idx_q;
		if (is_submit) begin
			tw      = use_hit ? hit_wkr_q : best_idx_q;
			load_ok = !reject;
		end else begin
			tw      = WIDX_W'(req_q.done_worker);
			load_ok = 32'(req_q.done_worker) < 32'(n_act);
		end
		if (is_submit)
			new_load = (load_rd_q == CNT_MAX) ? load_rd_q : load_rd_q + CNT_W'(1);
		else
			new_load = (load_rd_q == '0) ? load_rd_q : load_rd_q - CNT_W'(1);
		cnt_inc     = (hit_cnt_q == CNT_MAX) ? hit_cnt_q : hit_cnt_q + CNT_W'(1);
		cnt_dec     = (hit_cnt_q == '0) ? hit_cnt_q : hit_cnt_q - CNT_W'(1);
		fin_release = hit_q && (cnt_dec == '0);

		rsp_d.echo_source = req_q.source_id;
		if (!is_submit) begin
			rsp_d.status          = ST_FINISHED;
			rsp_d.assigned_worker = 4'd0;
			rsp_d.release_res     = fin_release;
		end else if (reject) begin
			rsp_d.status          = ST_REJECTED;
			rsp_d.assigned_worker = 4'd0;
			rsp_d.release_res     = 1'b1;
		end else begin
			rsp_d.status          = ST_DISPATCHED;
			rsp_d.assigned_worker = 4'(tw);
			rsp_d.release_res     = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_q <= KEEP_ORDER_RST;
			wiu_q  <= WORKERS_IN_USE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_KEEP_ORDER:     keep_q <= cfg_wdata[0];
				REG_WORKERS_IN_USE: wiu_q  <= cfg_wdata[4:0];
				default: begin
				end
			endcase
		end
	end

	// scan
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
		end else if (dp_cmd.start) begin
			scan_idx_q <= '0;
			hit_q      <= 1'b0;
			free_q     <= 1'b0;
		end else if (dp_cmd.scan) begin
			scan_idx_q <= scan_idx_q + SCAN_W'(1);
			if (ent_in && entry_valid_q[ei] && !hit_q &&
				entry_source_q[ei] == req_q.source_id)
				hit_q <= 1'b1;
			if (ent_in && !entry_valid_q[ei] && !free_q)
				free_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.start) begin
			req_q       <= in_data;
			best_idx_q  <= '0;
			best_load_q <= '0;
		end else if (dp_cmd.scan) begin
			if (ent_in && entry_valid_q[ei] && !hit_q &&
				entry_source_q[ei] == req_q.source_id) begin
				hit_idx_q <= ei;
				hit_cnt_q <= entry_count_q[ei];
				hit_wkr_q <= entry_worker_q[ei];
			end
			if (ent_in && !entry_valid_q[ei] && !free_q)
				free_idx_q <= ei;
			if (wkr_in && (scan_idx_q == '0 || worker_load_q[wi] < best_load_q)) begin
				best_idx_q  <= wi;
				best_load_q <= worker_load_q[wi];
			end
		end
		if (dp_cmd.lookup)
			load_rd_q <= worker_load_q[tw];
		if (dp_cmd.commit)
			rsp_q <= rsp_d;
	end

	// state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_WORKERS; i++)
				worker_load_q[i] <= '0;
			for (int i = 0; i < TABLE_ENTRIES; i++)
				entry_valid_q[i] <= 1'b0;
		end else if (dp_cmd.commit) begin
			if (load_ok)
				worker_load_q[tw] <= new_load;
			if (is_submit && new_entry)
				entry_valid_q[slot] <= 1'b1;
			if (!is_submit && fin_release)
				entry_valid_q[hit_idx_q] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.commit) begin
			if (is_submit && use_hit) begin
				entry_count_q[hit_idx_q] <= cnt_inc;
			end else if (is_submit && new_entry) begin
				entry_source_q[slot] <= req_q.source_id;
				entry_count_q[slot]  <= CNT_W'(1);
				entry_worker_q[slot] <= best_idx_q;
			end else if (!is_submit && hit_q) begin
				entry_count_q[hit_idx_q] <= cnt_dec;
			end
		end
	end

	assign out_data = rsp_q;

endmodule

/* design/least_loaded_dispatch_with_affinity_unit.sv */
// ----------------------------------------------------------------------------
// least_loaded_dispatch_with_affinity_unit
// Task dispatcher: least-loaded worker choice with per-source affinity.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready/in_data): submit or finish transactions.
// Output channel (out_valid/out_ready/out_data): one result per transaction.
// Config port (cfg_we/cfg_index/cfg_wdata): index 0 keep_order,
// index 1 workers_in_use; write only while the unit is idle.
// One transaction at a time: after acceptance a sequential scan reads one
// affinity entry and one worker load per cycle, then a lookup step reads the
// target worker load and a commit step applies the update and loads the
// output register. in_ready returns together with out_valid once the commit
// completes, and the next transaction can then be accepted.
// A new transaction is accepted while a result waits in the output register;
// if the receiver still stalls when the next result is ready, the commit
// waits with state unchanged until the output register frees.
// Reset clears all worker loads and affinity valid bits and sets
// keep_order to 1 and workers_in_use to 16.
// ----------------------------------------------------------------------------
module least_loaded_dispatch_with_affinity_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  lld_pkg::req_t                   in_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output lld_pkg::rsp_t                   out_data,
	input  logic                            cfg_we,
	input  logic [lld_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [lld_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
	import lld_pkg::*;

	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	lld_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

	lld_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.dp_cmd    (dp_cmd),
		.dp_stat   (dp_stat)
	);

endmodule
